>>> src/stt_pkg.sv
// Types and constants shared by the source text tokenizer.
// No dependencies.
package stt_pkg;

    localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

    localparam logic [2:0] EV_VALUE = 3'd0;
    localparam logic [2:0] EV_SYMBOL = 3'd1;
    localparam logic [2:0] EV_OPEN = 3'd2;
    localparam logic [2:0] EV_CLOSE = 3'd3;
    localparam logic [2:0] EV_LCOM = 3'd4;
    localparam logic [2:0] EV_ERROR = 3'd5;

    localparam logic [2:0] VK_WORD = 3'd0;
    localparam logic [2:0] VK_INT = 3'd1;
    localparam logic [2:0] VK_FLOAT = 3'd2;
    localparam logic [2:0] VK_HEX = 3'd3;
    localparam logic [2:0] VK_SQ = 3'd4;
    localparam logic [2:0] VK_DQ = 3'd5;

    localparam logic [1:0] ER_PARSE = 2'd0;
    localparam logic [1:0] ER_SCOPE = 2'd1;
    localparam logic [1:0] ER_CR = 2'd2;
    localparam logic [1:0] ER_SYM = 2'd3;

    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_TAB = 8'd9;

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_NUM, M_HEX, M_SLASH, M_LCOM, M_BCOM, M_BSTAR,
        M_CR, M_SQ, M_DQ, M_SQESC, M_DQESC
    } t_mode;

    // one token event; 95 bits
    typedef struct packed {
        logic       last;
        logic [5:0] depth;
        logic [7:0] ch;
        logic [23:0] len;
        logic [23:0] start;
        logic [23:0] line;
        logic [1:0] ek;
        logic [2:0] vk;
        logic [2:0] kind;
    } t_event;

    function automatic logic [23:0] sat_inc(input logic [23:0] x);
        return (x == CNT_MAX) ? x : x + 24'd1;
    endfunction

endpackage

>>> src/source_text_tokenizer_unit.sv
// Source text tokenizer: byte stream in, token events out.
// Uses stt_pkg.
//
// Slave channel takes one text byte per transfer: tdata[7:0] is the byte,
// tuser[0] first_byte (restart text), tlast end_of_text.
// Master channel gives token events; tlast marks the last event caused by
// one input byte. A byte causes zero to three events.
// Throughput: one byte per cycle while each byte gives at most one event
// and the receiver takes them; a byte with two or three events holds the input
// while they drain from the event buffer.
// A byte's events are written into the event buffer when it is accepted.
// The bracket stack lives in a memory with a registered read; the
// top-of-stack entry is held in a register so a close bracket resolves in
// the byte's own cycle, and the next entry down is refilled from the memory
// after each pop (forwarded when a close bracket follows at once).
// Reset clears counters, mode and halt; the stack needs no clearing.
// A stalled receiver fills the event buffer; s_tready drops once it holds two or more events.
module source_text_tokenizer_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic [0:0]  s_tuser,   // first_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    // line_number, token_start, token_length, char_code, nest_depth
    output logic [87:0] m_tdata,
    output logic [7:0]  m_tuser,   // event_kind, value_kind, error_kind
    output logic        m_tlast
);
    import stt_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    // ---------------- state
    t_mode       r_mode;
    logic [DW-1:0] r_depth;
    logic [23:0] r_line, r_pos, r_tbeg, r_cnb;
    logic        r_float, r_halt;
    logic [1:0]  r_top;        // cached stack top
    logic [1:0]  r_stk [STACK_DEPTH];
    logic [1:0]  r_rd;         // registered memory read
    logic        r_refill;     // r_rd must become r_top

    // event buffer (4 entries)
    t_event r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    // ---------------- combinational lexer
    t_mode       n_mode;
    logic [DW-1:0] n_depth;
    logic [23:0] n_line, n_tbeg, n_cnb;
    logic        n_float, n_halt;
    t_event      ev [3];
    logic [1:0]  n_ev;
    logic        push, pop;
    logic [1:0]  push_code;
    logic [1:0]  top_now;
    logic [7:0]  b;
    logic        first, last, fire;
    logic [23:0] pos, line0, tbeg0, cnb0;
    t_mode       mode0;
    logic [DW-1:0] depth0;
    logic        halt0, float0, used;

    assign b = s_tdata;
    assign first = s_tuser[0];
    assign last = s_tlast;
    assign s_tready = (r_cnt <= 3'd1);
    assign fire = s_tvalid && s_tready;
    assign top_now = r_refill ? r_rd : r_top;

    function automatic logic [1:0] bcode(input logic [7:0] c);
        if (c == "{" || c == "}") return 2'd0;
        if (c == "(" || c == ")") return 2'd1;
        return 2'd2;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == "_";
    endfunction

    function automatic logic is_sym(input logic [7:0] c);
        return c == "#" || c == "*" || c == "-" || c == "+" || c == "%" ||
               c == "|" || c == "^" || c == "&" || c == "=" || c == "!" ||
               c == "<" || c == ">" || c == "?" || c == "." || c == "@" ||
               c == ":" || c == ";" || c == "," || c == "~";
    endfunction

    always_comb begin
        t_event e;
        logic [2:0] vk;
        logic [23:0] endp;
        e = '0;
        vk = VK_WORD;
        endp = '0;
        for (int k = 0; k < 3; k++) ev[k] = '0;
        n_ev = '0;
        push = 1'b0;
        pop = 1'b0;
        push_code = '0;
        used = 1'b0;
        pos = first ? 24'd0 : r_pos;
        line0 = first ? 24'd0 : r_line;
        tbeg0 = first ? 24'd0 : r_tbeg;
        cnb0 = first ? 24'd0 : r_cnb;
        mode0 = first ? M_IDLE : r_mode;
        depth0 = first ? '0 : r_depth;
        halt0 = first ? 1'b0 : r_halt;
        float0 = first ? 1'b0 : r_float;
        n_mode = mode0;
        n_depth = depth0;
        n_line = line0;
        n_tbeg = tbeg0;
        n_cnb = cnb0;
        n_float = float0;
        n_halt = halt0;
        if (!halt0) begin
            // value kind of the open token
            case (mode0)
                M_WORD:  vk = VK_WORD;
                M_HEX:   vk = VK_HEX;
                M_NUM:   vk = float0 ? VK_FLOAT : VK_INT;
                M_SQ, M_SQESC: vk = VK_SQ;
                default: vk = VK_DQ;
            endcase
            // continue the open token
            case (mode0)
                M_WORD, M_HEX: begin
                    if (is_alnum(b)) used = 1'b1;
                    else begin
                        e = '0; e.kind = EV_VALUE; e.vk = vk; e.line = n_line;
                        e.start = tbeg0; e.len = (pos >= tbeg0) ? pos - tbeg0 : '0;
                        e.depth = 6'(n_depth);
                        ev[n_ev] = e; n_ev = n_ev + 2'd1; n_mode = M_IDLE;
                    end
                end
                M_NUM: begin
                    if (b >= "0" && b <= "9") used = 1'b1;
                    else if (b == ".") begin used = 1'b1; n_float = 1'b1; end
                    else begin
                        e = '0; e.kind = EV_VALUE; e.vk = vk; e.line = n_line;
                        e.start = tbeg0; e.len = (pos >= tbeg0) ? pos - tbeg0 : '0;
                        e.depth = 6'(n_depth);
                        ev[n_ev] = e; n_ev = n_ev + 2'd1; n_mode = M_IDLE;
                    end
                end
                M_SLASH: begin
                    if (b == "/") begin
                        used = 1'b1; n_mode = M_LCOM;
                        n_tbeg = sat_inc(pos); n_cnb = sat_inc(pos);
                    end else if (b == "*") begin
                        used = 1'b1; n_mode = M_BCOM;
                    end else begin
                        e = '0; e.kind = EV_SYMBOL; e.line = n_line; e.start = tbeg0;
                        e.len = 24'd1; e.ch = "/"; e.depth = 6'(n_depth);
                        ev[n_ev] = e; n_ev = n_ev + 2'd1; n_mode = M_IDLE;
                    end
                end
                M_LCOM: begin
                    if (b == CH_LF || b == CH_CR) begin
                        e = '0; e.kind = EV_LCOM; e.line = n_line; e.start = tbeg0;
                        e.len = (cnb0 >= tbeg0) ? cnb0 - tbeg0 : '0;
                        e.depth = 6'(n_depth);
                        ev[n_ev] = e; n_ev = n_ev + 2'd1; n_mode = M_IDLE;
                    end else begin
                        used = 1'b1;
                        if (b == " " || b == CH_TAB) begin
                            if (cnb0 == tbeg0) begin
                                n_tbeg = sat_inc(pos); n_cnb = sat_inc(pos);
                            end
                        end else n_cnb = sat_inc(pos);
                    end
                end
                M_BCOM, M_BSTAR: begin
                    used = 1'b1;
                    if (mode0 == M_BSTAR && b == "/") n_mode = M_IDLE;
                    else if (b == "*") n_mode = M_BSTAR;
                    else begin
                        if (b == CH_LF) n_line = sat_inc(n_line);
                        n_mode = M_BCOM;
                    end
                end
                M_CR: begin
                    used = 1'b1;
                    if (b == CH_LF) begin
                        n_line = sat_inc(n_line); n_mode = M_IDLE;
                    end else begin
                        e = '0; e.kind = EV_ERROR; e.ek = ER_CR; e.line = n_line;
                        e.start = pos; e.depth = 6'(n_depth);
                        ev[n_ev] = e; n_ev = n_ev + 2'd1;
                        n_halt = 1'b1; n_mode = M_IDLE;
                    end
                end
                M_SQ, M_DQ: begin
                    used = 1'b1;
                    if (b == ((mode0 == M_SQ) ? 8'd39 : 8'd34)) begin
                        e = '0; e.kind = EV_VALUE; e.vk = vk; e.line = n_line;
                        e.start = tbeg0; e.len = (pos >= tbeg0) ? pos - tbeg0 : '0;
                        e.depth = 6'(n_depth);
                        ev[n_ev] = e; n_ev = n_ev + 2'd1; n_mode = M_IDLE;
                    end else if (b == "\\")
                        n_mode = (mode0 == M_SQ) ? M_SQESC : M_DQESC;
                end
                M_SQESC: begin used = 1'b1; n_mode = M_SQ; end
                M_DQESC: begin used = 1'b1; n_mode = M_DQ; end
                default: begin n_mode = M_IDLE; end
            endcase
            // byte starts something new
            if (!used && !n_halt) begin
                e = '0; e.line = n_line; e.start = pos; e.len = 24'd1; e.ch = b;
                if (b == "/") begin
                    n_mode = M_SLASH; n_tbeg = pos;
                end else if (b == " " || b == CH_TAB) begin
                end else if (b == CH_LF) begin
                    n_line = sat_inc(n_line);
                end else if (b == CH_CR) begin
                    n_mode = M_CR;
                end else if (b == "{" || b == "(" || b == "[") begin
                    if (32'(depth0) >= STACK_DEPTH) begin
                        e.kind = EV_ERROR; e.ek = ER_PARSE; e.len = '0; e.ch = '0;
                        n_halt = 1'b1; n_mode = M_IDLE;
                    end else begin
                        push = 1'b1; push_code = bcode(b);
                        n_depth = depth0 + 1'b1; e.kind = EV_OPEN;
                    end
                    e.depth = 6'(n_depth);
                    ev[n_ev] = e; n_ev = n_ev + 2'd1;
                end else if (b == "}" || b == ")" || b == "]") begin
                    if (depth0 == '0 || top_now != bcode(b)) begin
                        e.kind = EV_ERROR; e.ek = ER_SCOPE; e.len = '0; e.ch = '0;
                        n_halt = 1'b1; n_mode = M_IDLE;
                    end else begin
                        pop = 1'b1; n_depth = depth0 - 1'b1; e.kind = EV_CLOSE;
                    end
                    e.depth = 6'(n_depth);
                    ev[n_ev] = e; n_ev = n_ev + 2'd1;
                end else if (is_sym(b)) begin
                    e.kind = EV_SYMBOL; e.depth = 6'(n_depth);
                    ev[n_ev] = e; n_ev = n_ev + 2'd1;
                end else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
                             b == "_") begin
                    n_mode = M_WORD; n_tbeg = pos;
                end else if (b >= "0" && b <= "9") begin
                    n_mode = M_NUM; n_tbeg = pos; n_float = 1'b0;
                end else if (b == "$") begin
                    n_mode = M_HEX; n_tbeg = sat_inc(pos);
                end else if (b == 8'd39) begin
                    n_mode = M_SQ; n_tbeg = sat_inc(pos);
                end else if (b == 8'd34) begin
                    n_mode = M_DQ; n_tbeg = sat_inc(pos);
                end else begin
                    e.kind = EV_ERROR; e.ek = ER_SYM; e.len = '0; e.ch = '0;
                    e.depth = 6'(n_depth);
                    ev[n_ev] = e; n_ev = n_ev + 2'd1;
                    n_halt = 1'b1; n_mode = M_IDLE;
                end
            end
            // end of text closes what is open
            if (last && !n_halt) begin
                endp = sat_inc(pos);
                e = '0; e.line = n_line; e.depth = 6'(n_depth);
                case (n_mode)
                    M_WORD, M_HEX, M_NUM: begin
                        e.kind = EV_VALUE; e.vk = (n_mode == M_WORD) ? VK_WORD :
                            (n_mode == M_HEX) ? VK_HEX : (n_float ? VK_FLOAT : VK_INT);
                        e.start = n_tbeg;
                        e.len = (endp >= n_tbeg) ? endp - n_tbeg : '0;
                        ev[n_ev] = e; n_ev = n_ev + 2'd1;
                    end
                    M_SLASH: begin
                        e.kind = EV_SYMBOL; e.start = n_tbeg; e.len = 24'd1; e.ch = "/";
                        ev[n_ev] = e; n_ev = n_ev + 2'd1;
                    end
                    M_LCOM: begin
                        e.kind = EV_LCOM; e.start = n_tbeg;
                        e.len = (n_cnb >= n_tbeg) ? n_cnb - n_tbeg : '0;
                        ev[n_ev] = e; n_ev = n_ev + 2'd1;
                    end
                    M_IDLE: begin
                    end
                    default: begin
                        e.kind = EV_ERROR; e.start = pos;
                        e.ek = (n_mode == M_CR) ? ER_CR : ER_PARSE;
                        ev[n_ev] = e; n_ev = n_ev + 2'd1; n_halt = 1'b1;
                    end
                endcase
                n_mode = M_IDLE;
                if (!n_halt && n_depth != '0) begin
                    e = '0; e.kind = EV_ERROR; e.ek = ER_SCOPE; e.line = n_line;
                    e.start = pos; e.depth = 6'(n_depth);
                    ev[n_ev] = e; n_ev = n_ev + 2'd1; n_halt = 1'b1;
                end
            end
            if (n_ev != '0) ev[n_ev - 2'd1].last = 1'b1;
        end
    end

    // ---------------- stack memory
    always_ff @(posedge i_clk) begin
        if (fire && push) r_stk[AW'(depth0)] <= push_code;
        // pop reads the new top entry from the memory
        if (fire && pop && depth0 >= DW'(2)) r_rd <= r_stk[AW'(depth0 - DW'(2))];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_depth <= '0;
            r_line <= '0;
            r_pos <= '0;
            r_tbeg <= '0;
            r_cnb <= '0;
            r_float <= 1'b0;
            r_halt <= 1'b0;
            r_refill <= 1'b0;
            r_top <= '0;
        end else begin
            if (r_refill) r_top <= r_rd;
            r_refill <= 1'b0;
            if (fire) begin
                r_mode <= n_mode;
                r_depth <= n_depth;
                r_line <= n_line;
                r_tbeg <= n_tbeg;
                r_cnb <= n_cnb;
                r_float <= n_float;
                r_halt <= n_halt;
                if (!halt0) r_pos <= sat_inc(pos);
                else r_pos <= pos;
                if (push) r_top <= push_code;
                else if (pop) r_refill <= 1'b1;
            end
        end
    end

    // ---------------- event buffer
    logic m_fire;
    assign m_fire = m_tvalid && m_tready;

    always_ff @(posedge i_clk) begin
        if (fire) begin
            for (int k = 0; k < 3; k++)
                if (2'(k) < n_ev) r_q[r_wp + 2'(k)] <= ev[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (fire) r_wp <= r_wp + n_ev;
            if (m_fire) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + (fire ? 3'(n_ev) : 3'd0) - (m_fire ? 3'd1 : 3'd0);
        end
    end

    t_event head;
    assign head = r_q[r_rp];
    assign m_tvalid = (r_cnt != '0);
    assign m_tdata = {2'b00, head.depth, head.ch, head.len, head.start, head.line};
    assign m_tuser = {head.ek, head.vk, head.kind};
    assign m_tlast = head.last;

    // ---------------- checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("event buffer overflow");
    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> r_cnt <= 3'd1) else $error("ready without room");
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_depth) <= STACK_DEPTH) else $error("stack depth out of range");
    a_refill_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_refill |=> !r_refill || $past(fire)) else $error("refill repeated");

endmodule
